// ===== design/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types and constants of the alarm clock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 6;
   localparam int unsigned TICK_W   = 32;
   localparam int unsigned IVL_W    = 16;
   localparam int unsigned KEY_W    = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = IVL_W;

   localparam logic [HOUR_W-1:0]   LAST_HOUR        = 5'd23;
   localparam logic [MINUTE_W-1:0] LAST_MINUTE      = 6'd59;
   localparam logic [HOUR_W-1:0]   RESET_ALARM_HOUR = 5'd7;
   localparam logic [IVL_W-1:0]    RESET_TONE_IVL   = 16'd180;
   localparam logic [IVL_W-1:0]    RESET_BL_IVL     = 16'd400;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_IVL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BL_IVL   = 1'b1;

   typedef enum logic [KEY_W-1:0] {
      KEY_PRESS   = 3'd0,
      KEY_RELEASE = 3'd1,
      KEY_SHORT   = 3'd2,
      KEY_LONG    = 3'd3,
      KEY_REPEAT  = 3'd4
   } key_kind_type;

   typedef enum logic [KEY_W-1:0] {
      KC_UP    = 3'd0,
      KC_DOWN  = 3'd1,
      KC_RIGHT = 3'd2,
      KC_LEFT  = 3'd3,
      KC_OK    = 3'd4,
      KC_BACK  = 3'd5
   } key_code_type;

   typedef enum logic [1:0] {
      RING_IDLE   = 2'b01,
      RING_ACTIVE = 2'b10
   } ring_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   now_hour;
      logic [MINUTE_W-1:0] now_minute;
      logic [TICK_W-1:0]   tick_ms;
      logic                key_valid;
      logic [KEY_W-1:0]    key_type;
      logic [KEY_W-1:0]    key_code;
      logic                speaker_granted;
   } req_type;

   typedef struct packed {
      logic                ringing;
      logic                vibro_on;
      logic                tone_start;
      logic                pitch_hi;
      logic                backlight_pulse;
      logic                speaker_stop;
      logic [HOUR_W-1:0]   alarm_hour_out;
      logic [MINUTE_W-1:0] alarm_minute_out;
      logic                armed_out;
      logic                cursor_out;
      logic                exit_request;
   } rsp_type;

   typedef struct packed {
      ring_type            ring;
      logic [HOUR_W-1:0]   set_hour;
      logic [MINUTE_W-1:0] set_minute;
      logic                armed;
      logic                cursor;
      logic                fired;
      logic                spk_held;
      logic                pitch_high;
      logic [TICK_W-1:0]   last_tone;
      logic [TICK_W-1:0]   last_bl;
   } state_type;

   typedef struct packed {
      logic [IVL_W-1:0] tone_ivl;
      logic [IVL_W-1:0] bl_ivl;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/acc_if.sv =====
// ----------------------------------------------------------------------------
// acc_if
// Valid/ready channels of the alarm clock controller: poll pass in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface acc_req_if
   import acc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [HOUR_W-1:0]   now_hour;
   logic [MINUTE_W-1:0] now_minute;
   logic [TICK_W-1:0]   tick_ms;
   logic                key_valid;
   logic [KEY_W-1:0]    key_type;
   logic [KEY_W-1:0]    key_code;
   logic                speaker_granted;

   modport source (
      output valid, now_hour, now_minute, tick_ms, key_valid, key_type, key_code,
             speaker_granted,
      input  ready
   );
   modport sink (
      input  valid, now_hour, now_minute, tick_ms, key_valid, key_type, key_code,
             speaker_granted,
      output ready
   );
endinterface

interface acc_rsp_if
   import acc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                ringing;
   logic                vibro_on;
   logic                tone_start;
   logic                pitch_hi;
   logic                backlight_pulse;
   logic                speaker_stop;
   logic [HOUR_W-1:0]   alarm_hour_out;
   logic [MINUTE_W-1:0] alarm_minute_out;
   logic                armed_out;
   logic                cursor_out;
   logic                exit_request;

   modport source (
      output valid, ringing, vibro_on, tone_start, pitch_hi, backlight_pulse,
             speaker_stop, alarm_hour_out, alarm_minute_out, armed_out, cursor_out,
             exit_request,
      input  ready
   );
   modport sink (
      input  valid, ringing, vibro_on, tone_start, pitch_hi, backlight_pulse,
             speaker_stop, alarm_hour_out, alarm_minute_out, armed_out, cursor_out,
             exit_request,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/alarm_clock_controller.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_controller
// Alarm clock poll controller: one result transaction per poll transaction.
// ----------------------------------------------------------------------------
// Each poll transaction on req_ch is registered, evaluated combinationally
// against the alarm state (trigger, tick compares, key decode) and produced
// as one result transaction on rsp_ch through the result register; a new
// pass is accepted every cycle while rsp_ch takes each result. The result
// register and the input register each hold one transaction, so while one
// result waits the block accepts one more transaction and then holds
// req_ch.ready low until the result is taken. The user writes tone and
// backlight intervals through csr_we/csr_index/csr_wdata while no pass is
// in flight; the block itself does not enforce this.
`default_nettype none

module alarm_clock_controller
   import acc_pkg::*;
(
   input  var logic                  clock,
   input  var logic                  reset,
   acc_req_if.sink                   req_ch,
   acc_rsp_if.source                 rsp_ch,
   input  var logic                  csr_we,
   input  var logic [CSR_IDX_W-1:0]  csr_index,
   input  var logic [CSR_DATA_W-1:0] csr_wdata
);

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   state_type state_ff;
   cfg_type   cfg_ff;
   state_type state_nxt;
   rsp_type   rsp_nxt;
   req_type   req_in;
   logic      out_free;
   logic      advance;
   logic      req_take;

   assign req_in.now_hour        = req_ch.now_hour;
   assign req_in.now_minute      = req_ch.now_minute;
   assign req_in.tick_ms         = req_ch.tick_ms;
   assign req_in.key_valid       = req_ch.key_valid;
   assign req_in.key_type        = req_ch.key_type;
   assign req_in.key_code        = req_ch.key_code;
   assign req_in.speaker_granted = req_ch.speaker_granted;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   acc_step u_step (
      .req (s1_req_ff),
      .cur (state_ff),
      .cfg (cfg_ff),
      .nxt (state_nxt),
      .rsp (rsp_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.ring       <= RING_IDLE;
         state_ff.set_hour   <= RESET_ALARM_HOUR;
         state_ff.set_minute <= '0;
         state_ff.armed      <= 1'b0;
         state_ff.cursor     <= 1'b0;
         state_ff.fired      <= 1'b0;
         state_ff.spk_held   <= 1'b0;
         state_ff.pitch_high <= 1'b1;
         state_ff.last_tone  <= '0;
         state_ff.last_bl    <= '0;
         cfg_ff.tone_ivl     <= RESET_TONE_IVL;
         cfg_ff.bl_ivl       <= RESET_BL_IVL;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
         if (csr_we) begin
            if (csr_index == CSR_TONE_IVL) begin
               cfg_ff.tone_ivl <= csr_wdata;
            end
            if (csr_index == CSR_BL_IVL) begin
               cfg_ff.bl_ivl <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_nxt;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.ringing          = rsp_ff.ringing;
   assign rsp_ch.vibro_on         = rsp_ff.vibro_on;
   assign rsp_ch.tone_start       = rsp_ff.tone_start;
   assign rsp_ch.pitch_hi         = rsp_ff.pitch_hi;
   assign rsp_ch.backlight_pulse  = rsp_ff.backlight_pulse;
   assign rsp_ch.speaker_stop     = rsp_ff.speaker_stop;
   assign rsp_ch.alarm_hour_out   = rsp_ff.alarm_hour_out;
   assign rsp_ch.alarm_minute_out = rsp_ff.alarm_minute_out;
   assign rsp_ch.armed_out        = rsp_ff.armed_out;
   assign rsp_ch.cursor_out       = rsp_ff.cursor_out;
   assign rsp_ch.exit_request     = rsp_ff.exit_request;

   // speaker is only held while ringing
   a_spk_held_ringing: assert property (@(posedge clock) disable iff (reset)
      state_ff.spk_held |-> (state_ff.ring == RING_ACTIVE))
      else $error("speaker held while idle");

   a_alarm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.set_hour <= LAST_HOUR) && (state_ff.set_minute <= LAST_MINUTE))
      else $error("alarm time out of range");

   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.speaker_stop) |-> (!rsp_ff.ringing && !rsp_ff.armed_out))
      else $error("speaker stop without disarm");

   // state only moves when a transaction passes into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a transaction");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.ringing == (state_ff.ring == RING_ACTIVE))
                  && (rsp_ff.alarm_hour_out == state_ff.set_hour)
                  && (rsp_ff.armed_out == state_ff.armed))
      else $error("result does not reflect updated state");

endmodule

`default_nettype wire

// ===== design/acc_step.sv =====
// ----------------------------------------------------------------------------
// acc_step
// Next-state and result logic for one poll pass: trigger, ringing, keys.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_step
   import acc_pkg::*;
(
   input  var req_type   req,
   input  var state_type cur,
   input  var cfg_type   cfg,
   output var state_type nxt,
   output var rsp_type   rsp
);

   logic              at_alarm;
   logic              ringing;
   logic [TICK_W-1:0] tone_diff;
   logic [TICK_W-1:0] bl_diff;
   logic              tone_due;
   logic              bl_due;

   assign at_alarm = (req.now_hour == cur.set_hour) && (req.now_minute == cur.set_minute);

   always_comb begin
      nxt = cur;
      rsp = '0;

      // trigger
      if ((cur.ring == RING_IDLE) && cur.armed && at_alarm) begin
         if (!cur.fired) begin
            nxt.fired = 1'b1;
            nxt.ring  = RING_ACTIVE;
            if (req.speaker_granted) begin
               nxt.spk_held = 1'b1;
            end
         end
      end else if (req.now_minute != cur.set_minute) begin
         nxt.fired = 1'b0;
      end

      ringing   = (nxt.ring == RING_ACTIVE);
      tone_diff = req.tick_ms - cur.last_tone;
      bl_diff   = req.tick_ms - cur.last_bl;
      tone_due  = tone_diff > {{(TICK_W-IVL_W){1'b0}}, cfg.tone_ivl};
      bl_due    = bl_diff > {{(TICK_W-IVL_W){1'b0}}, cfg.bl_ivl};

      // ringing actions
      if (ringing) begin
         if (nxt.spk_held && tone_due) begin
            nxt.pitch_high = ~cur.pitch_high;
            nxt.last_tone  = req.tick_ms;
            rsp.tone_start = 1'b1;
         end
         if (bl_due) begin
            nxt.last_bl         = req.tick_ms;
            rsp.backlight_pulse = 1'b1;
         end
      end

      // keys
      if (req.key_valid) begin
         if (ringing) begin
            if ((req.key_type == KEY_PRESS) || (req.key_type == KEY_SHORT)) begin
               if (nxt.spk_held) begin
                  rsp.speaker_stop = 1'b1;
                  nxt.spk_held     = 1'b0;
               end
               nxt.ring  = RING_IDLE;
               nxt.armed = 1'b0;
            end
         end else if ((req.key_type == KEY_SHORT) || (req.key_type == KEY_REPEAT)) begin
            unique case (req.key_code)
               KC_UP: begin
                  if (!cur.cursor) begin
                     nxt.set_hour = (cur.set_hour == LAST_HOUR) ? '0
                                  : cur.set_hour + HOUR_W'(1);
                  end else begin
                     nxt.set_minute = (cur.set_minute == LAST_MINUTE) ? '0
                                    : cur.set_minute + MINUTE_W'(1);
                  end
                  nxt.fired = 1'b0;
               end
               KC_DOWN: begin
                  if (!cur.cursor) begin
                     nxt.set_hour = (cur.set_hour == '0) ? LAST_HOUR
                                  : cur.set_hour - HOUR_W'(1);
                  end else begin
                     nxt.set_minute = (cur.set_minute == '0) ? LAST_MINUTE
                                    : cur.set_minute - MINUTE_W'(1);
                  end
                  nxt.fired = 1'b0;
               end
               KC_RIGHT, KC_LEFT: begin
                  nxt.cursor = ~cur.cursor;
               end
               KC_OK: begin
                  nxt.armed = ~cur.armed;
                  // arming inside the alarm minute counts as already fired
                  if (!cur.armed) begin
                     nxt.fired = at_alarm;
                  end
               end
               KC_BACK: begin
                  rsp.exit_request = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      rsp.ringing          = (nxt.ring == RING_ACTIVE);
      rsp.vibro_on         = (nxt.ring == RING_ACTIVE);
      rsp.pitch_hi         = nxt.pitch_high;
      rsp.alarm_hour_out   = nxt.set_hour;
      rsp.alarm_minute_out = nxt.set_minute;
      rsp.armed_out        = nxt.armed;
      rsp.cursor_out       = nxt.cursor;
   end

endmodule

`default_nettype wire
